// ----- rtl/tss_pkg.sv -----
// Shared constants, types and the tanh table of the tube saturator.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int TONE_COEFF       = 13600;
  localparam int TANH_TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS      = 24;

  localparam int TANH_IDX_W  = $clog2(TANH_TABLE_DEPTH);
  localparam int TANH_FRAC_W = 29 - TANH_IDX_W;
  localparam int TANH_ADDR_W = $clog2(TANH_TABLE_DEPTH + 1);

  localparam int DRIVE_MIN = 410;
  localparam int DRIVE_MAX = 40960;
  localparam int SAT_HI    = (2 ** (SAMPLE_BITS - 1)) - 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OGAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENVAMT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd7;

  typedef enum logic [1:0] {
    MODE_BYPASS = 2'd0,
    MODE_SOFT   = 2'd1,
    MODE_HARD   = 2'd2,
    MODE_ASYM   = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ENV, ST_MOD, ST_DRV, ST_LP, ST_TILT, ST_U, ST_SQ, ST_HS,
    ST_LKA1, ST_LKB1, ST_LKA2, ST_LKB2, ST_SH1, ST_SH2, ST_MX1, ST_MX2,
    ST_MX3, ST_FIN
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_ENV, CMD_MOD, CMD_DRV, CMD_LP, CMD_TILT, CMD_U,
    CMD_SQ, CMD_HS, CMD_LKA_MAIN, CMD_LKB_MAIN, CMD_LKA_SQ, CMD_LKB_SQ,
    CMD_SH1, CMD_SH2, CMD_MX1, CMD_MX2, CMD_MX3, CMD_FIN
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    chan;
  } dp_ctrl_t;

  typedef struct packed {
    logic stereo;
  } dp_status_t;

  typedef logic [23:0] tanh_rom_t [0:TANH_TABLE_DEPTH];

  // Shift-and-subtract quotient, used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x5;
    logic [63:0] t;
    logic [63:0] den;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      a  = (64'(i) << 33) / 64'(TANH_TABLE_DEPTH);
      x  = a >> 8;
      x2 = (x * x) >> 31;
      x3 = (x2 * x) >> 31;
      x5 = (x3 * x2) >> 31;
      t  = x - x3 / 64'd3 + (64'd2 * x5) / 64'd15;
      for (int k = 0; k < 8; k++) begin
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
        den = (64'd1 << 31) + ((t * t) >> 31);
        t   = udiv64(t << 32, den);
      end
      if (t > 64'h8000_0000) t = 64'h8000_0000;
      rom[i] = 24'((t + 64'd128) >> 8);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  function automatic logic [23:0] abs24(logic signed [23:0] v);
    return v[23] ? 24'(-v) : 24'(v);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tss_ctrl.sv -----
// Step sequencer of the saturator: handshakes and datapath commands.
`timescale 1ns / 1ps
`default_nettype none
module tss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  tss_pkg::dp_status_t status_i,
  output tss_pkg::dp_ctrl_t   ctrl_o
);
  import tss_pkg::*;

  state_e state_q, state_d;
  logic   chan_q, chan_d;
  logic   m_valid_q, m_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = s_valid_i && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin : p_next
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_ENV;
      ST_ENV:  state_d = ST_MOD;
      ST_MOD:  state_d = ST_DRV;
      ST_DRV:  state_d = ST_LP;
      ST_LP:   state_d = ST_TILT;
      ST_TILT: state_d = ST_U;
      ST_U:    state_d = ST_SQ;
      ST_SQ:   state_d = ST_HS;
      ST_HS:   state_d = ST_LKA1;
      ST_LKA1: state_d = ST_LKB1;
      ST_LKB1: state_d = ST_LKA2;
      ST_LKA2: state_d = ST_LKB2;
      ST_LKB2: state_d = ST_SH1;
      ST_SH1:  state_d = ST_SH2;
      ST_SH2:  state_d = ST_MX1;
      ST_MX1:  state_d = ST_MX2;
      ST_MX2:  state_d = ST_MX3;
      ST_MX3:  state_d = (!chan_q && status_i.stereo) ? ST_LP : ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin : p_out
    ctrl_o.chan = chan_q;
    ctrl_o.cmd  = CMD_NONE;
    s_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (accept) ctrl_o.cmd = CMD_LOAD;
      end
      ST_ENV:  ctrl_o.cmd = CMD_ENV;
      ST_MOD:  ctrl_o.cmd = CMD_MOD;
      ST_DRV:  ctrl_o.cmd = CMD_DRV;
      ST_LP:   ctrl_o.cmd = CMD_LP;
      ST_TILT: ctrl_o.cmd = CMD_TILT;
      ST_U:    ctrl_o.cmd = CMD_U;
      ST_SQ:   ctrl_o.cmd = CMD_SQ;
      ST_HS:   ctrl_o.cmd = CMD_HS;
      ST_LKA1: ctrl_o.cmd = CMD_LKA_MAIN;
      ST_LKB1: ctrl_o.cmd = CMD_LKB_MAIN;
      ST_LKA2: ctrl_o.cmd = CMD_LKA_SQ;
      ST_LKB2: ctrl_o.cmd = CMD_LKB_SQ;
      ST_SH1:  ctrl_o.cmd = CMD_SH1;
      ST_SH2:  ctrl_o.cmd = CMD_SH2;
      ST_MX1:  ctrl_o.cmd = CMD_MX1;
      ST_MX2:  ctrl_o.cmd = CMD_MX2;
      ST_MX3:  ctrl_o.cmd = CMD_MX3;
      ST_FIN:  if (out_free) ctrl_o.cmd = CMD_FIN;
      default: ctrl_o.cmd = CMD_NONE;
    endcase
  end

  always_comb begin : p_aux
    chan_d    = chan_q;
    m_valid_d = m_valid_q && !m_ready_i;
    if (state_q == ST_DRV) chan_d = 1'b0;
    if (state_q == ST_MX3 && status_i.stereo) chan_d = 1'b1;
    if (state_q == ST_FIN && out_free) m_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chan_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chan_q    <= chan_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule
`default_nettype wire

// ----- rtl/tss_datapath.sv -----
// Datapath of the saturator: registers, filters, tanh lookup, mix and meters.
`timescale 1ns / 1ps
`default_nettype none
module tss_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tss_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [tss_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [23:0]                         left_in_i,
  input  logic [23:0]                         right_in_i,
  input  logic                                stereo_i,
  input  logic                                block_start_i,
  input  tss_pkg::dp_ctrl_t                   ctrl_i,
  output tss_pkg::dp_status_t                 status_o,
  output logic [23:0]                         left_out_o,
  output logic [23:0]                         right_out_o,
  output logic [23:0]                         input_peak_o,
  output logic [23:0]                         output_peak_o,
  output logic [15:0]                         drive_peak_o
);
  import tss_pkg::*;

  // configuration
  mode_e              mode_q;
  logic [15:0]        gain_q;
  logic [16:0]        bias_q;
  logic signed [15:0] tilt_q;
  logic [15:0]        ogain_q;
  logic [15:0]        wetf_q;
  logic signed [15:0] envamt_q;
  logic [31:0]        smooth_q;

  // state
  logic [23:0]        env_q, env_d;
  logic signed [27:0] lpl_q, lpl_d, lpr_q, lpr_d;
  logic [23:0]        ipk_q, ipk_d, opk_q, opk_d;
  logic [15:0]        dpk_q, dpk_d;

  // frame working registers
  logic signed [23:0] dl_q, dl_d, dr_q, dr_d;
  logic               st_q, st_d;
  logic [23:0]        inabs_q, inabs_d;
  logic [17:0]        c_q, c_d;
  logic signed [25:0] mod_q, mod_d;
  logic [15:0]        drive_q, drive_d;
  logic signed [31:0] s_q, s_d;
  logic signed [35:0] u_q, u_d, arg_q, arg_d;
  logic [29:0]        sq_q, sq_d;
  logic signed [24:0] th1_q, th1_d, th2_q, th2_d;
  logic signed [26:0] t1_q, t1_d, wet_q, wet_d;
  logic signed [43:0] acc_q, acc_d;
  logic signed [23:0] ol_q, ol_d, or_q, or_d;

  // tanh lookup
  logic [TANH_ADDR_W-1:0] a0, a1;
  logic [23:0]            e0_q, e1_q;
  logic [TANH_FRAC_W-1:0] frac_q, frac_d;
  logic                   neg_q, neg_d;

  // result register
  logic [23:0] lo_q, lo_d, ro_q, ro_d, oip_q, oip_d, oop_q, oop_d;
  logic [15:0] odp_q, odp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BYPASS;
      gain_q   <= 16'd4096;
      bias_q   <= 17'd0;
      tilt_q   <= 16'sd0;
      ogain_q  <= 16'd16384;
      wetf_q   <= 16'd32768;
      envamt_q <= 16'sd0;
      smooth_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MODE:   mode_q   <= mode_e'(cfg_wdata_i[1:0]);
        REG_DRIVE:  gain_q   <= cfg_wdata_i[15:0];
        REG_BIAS:   bias_q   <= cfg_wdata_i[16:0];
        REG_TILT:   tilt_q   <= $signed(cfg_wdata_i[15:0]);
        REG_OGAIN:  ogain_q  <= cfg_wdata_i[15:0];
        REG_WET:    wetf_q   <= cfg_wdata_i[15:0];
        REG_ENVAMT: envamt_q <= $signed(cfg_wdata_i[15:0]);
        REG_SMOOTH: smooth_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin : p_step
    logic [23:0]        abs_l, abs_r, in_abs, out_abs;
    logic signed [23:0] rin;
    logic [33:0]        cst_prod;
    logic [15:0]        alpha;
    logic signed [24:0] env_diff;
    logic signed [41:0] env_prod;
    logic signed [41:0] env_sum;
    logic signed [40:0] mod_prod;
    logic signed [42:0] drv_prod;
    logic signed [19:0] drv_raw;
    logic signed [23:0] x;
    logic signed [27:0] x27, half, lp;
    logic signed [28:0] lp_diff;
    logic signed [45:0] lp_prod;
    logic signed [29:0] lp_sum;
    logic signed [29:0] tilt_v;
    logic signed [17:0] tilt_c;
    logic signed [47:0] tilt_prod;
    logic signed [48:0] u_prod;
    logic [35:0]        u_mag;
    logic [55:0]        sq_prod;
    logic signed [28:0] h;
    logic signed [46:0] hs_prod;
    logic signed [35:0] lk_v;
    logic [35:0]        lk_m;
    logic               lk_sat;
    logic signed [24:0] lk_d, lk_r, lk_t;
    logic signed [25+TANH_FRAC_W:0] lk_prod;
    logic signed [17:0] k1;
    logic signed [42:0] sh1_prod;
    logic [17:0]        k2;
    logic signed [43:0] sh2_prod;
    logic signed [17:0] wd;
    logic signed [41:0] mx1_prod;
    logic signed [43:0] mx2_prod;
    logic signed [60:0] out_prod;
    logic signed [31:0] out_raw;
    logic signed [23:0] res, lo, ro;

    env_d = env_q;  lpl_d = lpl_q;  lpr_d = lpr_q;
    ipk_d = ipk_q;  opk_d = opk_q;  dpk_d = dpk_q;
    dl_d = dl_q;  dr_d = dr_q;  st_d = st_q;  inabs_d = inabs_q;  c_d = c_q;
    mod_d = mod_q;  drive_d = drive_q;  s_d = s_q;  u_d = u_q;  arg_d = arg_q;
    sq_d = sq_q;  th1_d = th1_q;  th2_d = th2_q;  t1_d = t1_q;  wet_d = wet_q;
    acc_d = acc_q;  ol_d = ol_q;  or_d = or_q;
    lo_d = lo_q;  ro_d = ro_q;  oip_d = oip_q;  oop_d = oop_q;  odp_d = odp_q;

    rin     = stereo_i ? $signed(right_in_i) : $signed(left_in_i);
    abs_l   = abs24($signed(left_in_i));
    abs_r   = abs24(rin);
    in_abs  = (abs_l > abs_r) ? abs_l : abs_r;
    cst_prod = 34'(17'd42598 * bias_q);

    alpha    = (inabs_q > env_q) ? smooth_q[31:16] : smooth_q[15:0];
    env_diff = $signed({1'b0, inabs_q}) - $signed({1'b0, env_q});
    env_prod = $signed({1'b0, alpha}) * env_diff;
    env_sum  = 42'($signed({1'b0, env_q})) + (env_prod >>> 16);
    mod_prod = envamt_q * $signed({1'b0, env_q});
    drv_prod = $signed({1'b0, gain_q}) * mod_q;
    drv_raw  = $signed(drv_prod[42:23]);

    x    = ctrl_i.chan ? dr_q : dl_q;
    lp   = ctrl_i.chan ? lpr_q : lpl_q;
    x27  = $signed({x, 4'b0});
    half = $signed({x[23], x, 3'b0});

    lp_diff = 29'(x27) - 29'(lp);
    lp_prod = $signed(17'(TONE_COEFF)) * lp_diff;
    lp_sum  = 30'(lp) + 30'(lp_prod >>> 16);

    if (!tilt_q[15]) begin
      tilt_v = 30'(x27) - 30'(lp) - 30'(half);
      tilt_c = 18'(tilt_q);
    end else begin
      tilt_v = 30'(lp) - 30'(half);
      tilt_c = -18'(tilt_q);
    end
    tilt_prod = tilt_c * tilt_v;

    u_prod  = s_q * $signed({1'b0, drive_q});
    u_mag   = u_q[35] ? 36'(-u_q) : 36'(u_q);
    sq_prod = u_mag[27:0] * u_mag[27:0];

    if (u_q > 36'sd134217728)       h = 29'sd134217728;
    else if (u_q < -36'sd134217728) h = -29'sd134217728;
    else                            h = 29'(u_q);
    hs_prod = h * $signed(18'd85197);

    lk_v   = (ctrl_i.cmd == CMD_LKA_SQ) ? $signed({6'b0, sq_q}) : arg_q;
    lk_m   = lk_v[35] ? 36'(-lk_v) : 36'(lk_v);
    lk_sat = |lk_m[35:29];
    a0 = lk_sat ? TANH_ADDR_W'(TANH_TABLE_DEPTH)
                : TANH_ADDR_W'(lk_m[28 -: TANH_IDX_W]);
    a1 = lk_sat ? a0 : a0 + TANH_ADDR_W'(1);
    frac_d = lk_sat ? '0 : lk_m[TANH_FRAC_W-1:0];
    neg_d  = lk_v[35];

    lk_d    = $signed({1'b0, e1_q}) - $signed({1'b0, e0_q});
    lk_prod = lk_d * $signed({1'b0, frac_q});
    lk_r    = $signed({1'b0, e0_q}) + 25'(lk_prod >>> TANH_FRAC_W);
    lk_t    = neg_q ? -lk_r : lk_r;

    k1       = (mode_q == MODE_HARD) ? 18'sd55706 : 18'sd49152;
    sh1_prod = th1_q * k1;
    k2       = (mode_q == MODE_ASYM) ? c_q : {1'b0, bias_q};
    sh2_prod = $signed({1'b0, k2}) * th2_q;

    wd       = 18'sd32768 - $signed({2'b0, wetf_q});
    mx1_prod = x * wd;
    mx2_prod = wet_q * $signed({1'b0, wetf_q});
    out_prod = acc_q * $signed({1'b0, ogain_q});
    out_raw  = 32'(out_prod >>> 29);
    if (out_raw > 32'sd0 + SAT_HI)        res = 24'(32'(SAT_HI));
    else if (out_raw < -32'sd1 - SAT_HI)  res = 24'(-32'sd1 - SAT_HI);
    else                                  res = out_raw[23:0];

    lo = (mode_q == MODE_BYPASS) ? dl_q : ol_q;
    ro = st_q ? ((mode_q == MODE_BYPASS) ? dr_q : or_q) : lo;
    out_abs = (abs24(lo) > abs24(ro)) ? abs24(lo) : abs24(ro);

    case (ctrl_i.cmd)
      CMD_LOAD: begin
        dl_d    = $signed(left_in_i);
        dr_d    = rin;
        st_d    = stereo_i;
        inabs_d = in_abs;
        c_d     = 18'(22938) + 18'(cst_prod[33:16]);
        ipk_d   = (block_start_i || in_abs > ipk_q) ? in_abs : ipk_q;
        if (block_start_i) begin
          opk_d = '0;
          dpk_d = '0;
        end
      end
      CMD_ENV: env_d = env_sum[23:0];
      CMD_MOD: mod_d = 26'sd8388608 + $signed(mod_prod[40:15]);
      CMD_DRV: begin
        if (drv_raw < $signed(20'(DRIVE_MIN)))      drive_d = 16'(DRIVE_MIN);
        else if (drv_raw > $signed(20'(DRIVE_MAX))) drive_d = 16'(DRIVE_MAX);
        else                                        drive_d = drv_raw[15:0];
        if (drive_d > dpk_q) dpk_d = drive_d;
      end
      CMD_LP: begin
        if (ctrl_i.chan) lpr_d = lp_sum[27:0];
        else             lpl_d = lp_sum[27:0];
      end
      CMD_TILT: s_d = 32'(x27) + 32'(tilt_prod >>> 15);
      CMD_U:    u_d = 36'(u_prod >>> 12);
      CMD_SQ:   sq_d = (|u_mag[35:28]) ? 30'(1 << 29) : 30'(sq_prod[55:27]);
      CMD_HS:   arg_d = (mode_q == MODE_HARD) ? 36'(hs_prod >>> 16) : u_q;
      CMD_LKB_MAIN: th1_d = lk_t;
      CMD_LKB_SQ:   th2_d = lk_t;
      CMD_SH1: t1_d = (mode_q == MODE_HARD || mode_q == MODE_ASYM)
                      ? 27'(sh1_prod >>> 16) : 27'(th1_q);
      CMD_SH2: wet_d = t1_q + 27'(sh2_prod >>> 16);
      CMD_MX1: acc_d = 44'(mx1_prod);
      CMD_MX2: acc_d = acc_q + mx2_prod;
      CMD_MX3: begin
        if (ctrl_i.chan) or_d = res;
        else             ol_d = res;
      end
      CMD_FIN: begin
        opk_d = (out_abs > opk_q) ? out_abs : opk_q;
        lo_d  = lo;
        ro_d  = ro;
        oip_d = ipk_q;
        oop_d = opk_d;
        odp_d = dpk_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
      lpl_q <= '0;
      lpr_q <= '0;
      ipk_q <= '0;
      opk_q <= '0;
      dpk_q <= '0;
    end else begin
      env_q <= env_d;
      lpl_q <= lpl_d;
      lpr_q <= lpr_d;
      ipk_q <= ipk_d;
      opk_q <= opk_d;
      dpk_q <= dpk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q    <= TANH_ROM[a0];
    e1_q    <= TANH_ROM[a1];
    frac_q  <= frac_d;
    neg_q   <= neg_d;
    dl_q    <= dl_d;
    dr_q    <= dr_d;
    st_q    <= st_d;
    inabs_q <= inabs_d;
    c_q     <= c_d;
    mod_q   <= mod_d;
    drive_q <= drive_d;
    s_q     <= s_d;
    u_q     <= u_d;
    arg_q   <= arg_d;
    sq_q    <= sq_d;
    th1_q   <= th1_d;
    th2_q   <= th2_d;
    t1_q    <= t1_d;
    wet_q   <= wet_d;
    acc_q   <= acc_d;
    ol_q    <= ol_d;
    or_q    <= or_d;
    lo_q    <= lo_d;
    ro_q    <= ro_d;
    oip_q   <= oip_d;
    oop_q   <= oop_d;
    odp_q   <= odp_d;
  end

  assign status_o.stereo = st_q;
  assign left_out_o      = lo_q;
  assign right_out_o     = ro_q;
  assign input_peak_o    = oip_q;
  assign output_peak_o   = oop_q;
  assign drive_peak_o    = odp_q;

endmodule
`default_nettype wire

// ----- rtl/tube_saturator_stereo_top.sv -----
// A frame runs its envelope and drive steps once, then 14 steps per channel, left
// and then right for a stereo frame, with one shared tanh ROM.
// The block takes no new frame before the last one has passed its final step; a result
// waiting on the output delays the next frame only at its final step.
// Reset clears registers to their defaults, filters, envelope and meters.
`timescale 1ns / 1ps
`default_nettype none
module tube_saturator_stereo_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tss_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [tss_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // left_in, right_in
  input  logic [1:0]                        s_axis_tuser,  // stereo, block_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_out, right_out, input_peak, output_peak, drive_peak
  output logic [111:0]                      m_axis_tdata
);
  import tss_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  tss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .ctrl_o    (ctrl)
  );

  tss_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .left_in_i     (s_axis_tdata[23:0]),
    .right_in_i    (s_axis_tdata[47:24]),
    .stereo_i      (s_axis_tuser[0]),
    .block_start_i (s_axis_tuser[1]),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .left_out_o    (m_axis_tdata[23:0]),
    .right_out_o   (m_axis_tdata[47:24]),
    .input_peak_o  (m_axis_tdata[71:48]),
    .output_peak_o (m_axis_tdata[95:72]),
    .drive_peak_o  (m_axis_tdata[111:96])
  );

endmodule
`default_nettype wire

// ----- rtl/tss_checker.sv -----
// Port-level checks of the saturator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tss_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a frame is in work");

  a_drive_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[111:96] >= 16'd410 && m_axis_tdata[111:96] <= 16'd40960)
    else $error("drive peak outside clamp range");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:48] <= 24'h800000 && m_axis_tdata[95:72] <= 24'h800000)
    else $error("peak meter above full scale");

endmodule

bind tube_saturator_stereo_top tss_checker u_checker (.*);
`default_nettype wire
